@@ rtl/core/tld_pkg.sv @@
// ----------------------------------------------------------------------------
// tld_pkg
// Types and constants shared by the tty line discipline modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tld_pkg;

  // character codes used by the translations and echoes
  localparam logic [7:0] ChNl    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChSpace = 8'd32;

  // register reset values
  localparam logic [5:0] ModeReset     = 6'd60;
  localparam logic [7:0] EraseReset    = 8'd8;
  localparam logic [7:0] KillReset     = 8'd21;
  localparam logic [7:0] EofReset      = 8'd4;
  localparam logic [7:0] EolReset      = 8'd10;
  localparam logic [7:0] IntrReset     = 8'd3;
  localparam logic [7:0] SuspReset     = 8'd26;
  localparam logic [8:0] MaxLineReset  = 9'd256;

  // mode flag bits
  localparam int ModeNlToCr  = 0;
  localparam int ModeIgnCr   = 1;
  localparam int ModeCrToNl  = 2;
  localparam int ModeCanon   = 3;
  localparam int ModeEcho    = 4;
  localparam int ModeEchoNl  = 5;

  // result steps of one item, emitted lowest bit first
  localparam int StepWr   = 0;
  localparam int StepE0   = 1;
  localparam int StepE1   = 2;
  localparam int StepE2   = 3;
  localparam int StepTerm = 4;
  localparam int StepDone = 5;
  localparam int NumSteps = 6;

  // descriptor queue between front and back
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);
  localparam int QCntW    = $clog2(QDepth + 1);

  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_ERASE    = 3'd1,
    REG_KILL     = 3'd2,
    REG_EOF      = 3'd3,
    REG_EOL      = 3'd4,
    REG_INTR     = 3'd5,
    REG_SUSP     = 3'd6,
    REG_MAX_LINE = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    DEST_ECHO  = 2'd0,
    DEST_WRITE = 2'd1,
    DEST_LINE  = 2'd2
  } dest_e;

  typedef struct packed {
    logic [NumSteps-1:0] steps;
    logic [7:0]          ch;
    logic [8:0]          wr_pos;
    logic [7:0]          echo_ch;
    logic [8:0]          len;
  } desc_t;

endpackage

`default_nettype wire

@@ rtl/core/tty_line_discipline.sv @@
// ----------------------------------------------------------------------------
// tty_line_discipline
// Canonical tty line discipline: input translations, erase/kill editing,
// echo generation and line completion, one received character per beat.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   input     in         in_valid_i / in_stall_o  in_char_i
//   result    out        out_valid_o / out_stall_i dest_o out_char_o position_o
//                                                 last_o
//   config    in         cfg_we_i                 cfg_idx_i cfg_data_i
//
// the front takes one character per cycle while its 4-entry descriptor
// queue has room; the back emits one result beat per cycle unless the output
// stalls, so a character holds the back for its 1 to 4 result beats and the
// sustained rate is set by that single result register.
// reset is immediate: no clearing pass, line length and queue start empty.
// output stall holds the result register and the back; the queue then
// absorbs up to four characters before in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none

module tty_line_discipline import tld_pkg::*; #(
  parameter int MAX_LINE         = 256,
  parameter int CURSOR_LEFT_CODE = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [8:0] cfg_data_i,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] in_char_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      dest_o,
  output logic [7:0]      out_char_o,
  output logic [8:0]      position_o,
  output logic            last_o
);

  logic  push, pop, q_full, q_empty;
  desc_t push_desc, pop_desc;

  tld_front #(
    .MAX_LINE         (MAX_LINE),
    .CURSOR_LEFT_CODE (CURSOR_LEFT_CODE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_char_i  (in_char_i),
    .q_full_i   (q_full),
    .in_stall_o (in_stall_o),
    .push_o     (push),
    .desc_o     (push_desc)
  );

  tld_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_desc),
    .pop_i       (pop),
    .pop_data_o  (pop_desc),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  tld_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_data_i    (pop_desc),
    .q_empty_i   (q_empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .dest_o      (dest_o),
    .out_char_o  (out_char_o),
    .position_o  (position_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire

@@ rtl/core/tld_front.sv @@
// ----------------------------------------------------------------------------
// tld_front
// Holds the registers and line length, translates and classifies each
// received character into a descriptor of the results it causes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tld_front import tld_pkg::*; #(
  parameter int MAX_LINE         = 256,
  parameter int CURSOR_LEFT_CODE = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic [2:0] cfg_idx_i,
  input  wire logic [8:0] cfg_data_i,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] in_char_i,
  input  wire logic       q_full_i,
  output logic            in_stall_o,
  output logic            push_o,
  output desc_t           desc_o
);

  localparam int         CapLimitI = (MAX_LINE > 511) ? 511 : MAX_LINE;
  localparam logic [8:0] CapLimit  = 9'(CapLimitI);
  localparam logic [7:0] CursorLeft = 8'(CURSOR_LEFT_CODE);

  logic [5:0] mode_q;
  logic [7:0] erase_q, kill_q, eof_q, eol_q, intr_q, susp_q;
  logic [8:0] max_line_q;
  logic [8:0] len_q, len_d;

  logic       accept;
  logic [7:0] c0, ch;
  logic       ignore;
  logic [8:0] cap, store_pos, pos_inc, len_after, final_len;
  logic       canon, is_erase, is_kill, ends;
  desc_t      desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= ModeReset;
      erase_q    <= EraseReset;
      kill_q     <= KillReset;
      eof_q      <= EofReset;
      eol_q      <= EolReset;
      intr_q     <= IntrReset;
      susp_q     <= SuspReset;
      max_line_q <= MaxLineReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_MODE:     mode_q     <= cfg_data_i[5:0];
        REG_ERASE:    erase_q    <= cfg_data_i[7:0];
        REG_KILL:     kill_q     <= cfg_data_i[7:0];
        REG_EOF:      eof_q      <= cfg_data_i[7:0];
        REG_EOL:      eol_q      <= cfg_data_i[7:0];
        REG_INTR:     intr_q     <= cfg_data_i[7:0];
        REG_SUSP:     susp_q     <= cfg_data_i[7:0];
        REG_MAX_LINE: max_line_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input translations
  assign c0     = (in_char_i == ChNl && mode_q[ModeNlToCr]) ? ChCr : in_char_i;
  assign ignore = (c0 == ChCr) && mode_q[ModeIgnCr];
  assign ch     = (c0 == ChCr && mode_q[ModeCrToNl]) ? ChNl : c0;

  assign cap = (max_line_q == 9'd0) ? 9'd1 :
               ((max_line_q > CapLimit) ? CapLimit : max_line_q);
  // saturate to the last slot after max_line was lowered
  assign store_pos = (len_q < cap) ? len_q : cap - 9'd1;
  assign pos_inc   = store_pos + 9'd1;

  assign canon    = mode_q[ModeCanon];
  assign is_erase = (ch == erase_q);
  assign is_kill  = (ch == kill_q);

  always_comb begin
    desc        = '0;
    desc.ch     = ch;
    desc.wr_pos = store_pos;
    desc.echo_ch = ch;
    len_after   = pos_inc;
    ends        = 1'b0;
    final_len   = 9'd0;
    len_d       = len_q;

    if (canon && is_erase) begin
      len_after = (len_q != 9'd0) ? len_q - 9'd1 : len_q;
    end else if (canon && is_kill) begin
      len_after = 9'd0;
    end else begin
      desc.steps[StepWr] = 1'b1;
    end

    if (mode_q[ModeEcho]) begin
      desc.steps[StepE0] = 1'b1;
      if (canon && is_erase) begin
        desc.steps[StepE1] = 1'b1;
        desc.steps[StepE2] = 1'b1;
        desc.echo_ch       = CursorLeft;
      end else if (canon && is_kill) begin
        desc.echo_ch = ChNl;
      end
    end else if (ch == ChNl && mode_q[ModeEchoNl]) begin
      desc.steps[StepE0] = 1'b1;
      desc.echo_ch       = ChNl;
    end

    if (canon) begin
      ends = (ch == eof_q || ch == eol_q || ch == intr_q || ch == susp_q ||
              len_after >= cap) && !is_erase;
      final_len = (len_after >= cap) ? cap - 9'd1 : len_after;
      if (ends) begin
        desc.steps[StepTerm] = 1'b1;
        desc.steps[StepDone] = 1'b1;
        desc.len             = final_len;
        len_d                = 9'd0;
      end else begin
        len_d = len_after;
      end
    end else begin
      desc.steps[StepDone] = 1'b1;
      desc.len             = len_after;
      len_d                = 9'd0;
    end
  end

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign push_o     = accept && !ignore && (desc.steps != '0);
  assign desc_o     = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= 9'd0;
    end else if (accept && !ignore) begin
      len_q <= len_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tld_queue.sv @@
// ----------------------------------------------------------------------------
// tld_queue
// Short descriptor queue that decouples the classifier from the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tld_queue import tld_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  desc_t      push_data_i,
  input  wire logic  pop_i,
  output desc_t      pop_data_o,
  output logic       full_o,
  output logic       empty_o
);

  desc_t             mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;
  logic              do_push, do_pop;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign empty_o    = (cnt_q == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/tld_back.sv @@
// ----------------------------------------------------------------------------
// tld_back
// Expands one descriptor into its result beats, one beat per cycle unless
// the output stalls, through a registered output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tld_back import tld_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  desc_t           q_data_i,
  input  wire logic       q_empty_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      dest_o,
  output logic [7:0]      out_char_o,
  output logic [8:0]      position_o,
  output logic            last_o
);

  desc_t               cur_q;
  logic [NumSteps-1:0] steps_q, steps_d;
  logic [NumSteps-1:0] pick, rem;
  logic                can_emit, emit, free;
  logic                out_valid_q, out_valid_d;
  dest_e               dest_q, dest_d;
  logic [7:0]          char_q, char_d;
  logic [8:0]          pos_q, pos_d;
  logic                last_q, last_d;

  // lowest pending step goes next
  assign pick     = steps_q & (~steps_q + NumSteps'(1));
  assign rem      = steps_q & ~pick;
  assign can_emit = !out_valid_q || !out_stall_i;
  assign emit     = can_emit && (steps_q != '0);
  assign free     = (steps_q == '0) || (emit && rem == '0);
  assign pop_o    = free && !q_empty_i;

  always_comb begin
    steps_d = steps_q;
    if (pop_o) begin
      steps_d = q_data_i.steps;
    end else if (emit) begin
      steps_d = rem;
    end
  end

  always_comb begin
    dest_d = DEST_ECHO;
    char_d = 8'd0;
    pos_d  = 9'd0;
    last_d = (rem == '0);
    if (pick[StepWr]) begin
      dest_d = DEST_WRITE;
      char_d = cur_q.ch;
      pos_d  = cur_q.wr_pos;
    end else if (pick[StepE0] || pick[StepE2]) begin
      char_d = cur_q.echo_ch;
    end else if (pick[StepE1]) begin
      char_d = ChSpace;
    end else if (pick[StepTerm]) begin
      dest_d = DEST_WRITE;
      pos_d  = cur_q.len;
    end else begin
      dest_d = DEST_LINE;
      pos_d  = cur_q.len;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= q_data_i;
    end
    if (emit) begin
      dest_q <= dest_d;
      char_q <= char_d;
      pos_q  <= pos_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign dest_o      = dest_q;
  assign out_char_o  = char_q;
  assign position_o  = pos_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

@@ sim/tty_line_discipline_tb.sv @@
// ----------------------------------------------------------------------------
// tty_line_discipline_tb
// Self-checking bench for the tty line discipline. Characters go in through
// a queue-fed driver and each accepted beat is run through a local model of
// translation, erase/kill editing, echo and line completion. A monitor then
// checks every result beat in order. The stimulus covers a directed set of
// edge cases, then random register settings under three idling profiles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tty_line_discipline_tb;
  import tld_pkg::*;

  localparam int         MaxLine      = 256;
  localparam logic [7:0] CursorLeft   = 8'd8;
  localparam int         SettleCycles = 24;
  localparam int         HoldCycles   = 400;

  localparam logic [8:0] FNlCr   = 9'd1 << ModeNlToCr;
  localparam logic [8:0] FIgnCr  = 9'd1 << ModeIgnCr;
  localparam logic [8:0] FCrNl   = 9'd1 << ModeCrToNl;
  localparam logic [8:0] FCanon  = 9'd1 << ModeCanon;
  localparam logic [8:0] FEcho   = 9'd1 << ModeEcho;
  localparam logic [8:0] FEchoNl = 9'd1 << ModeEchoNl;

  typedef struct packed {
    dest_e      dest;
    logic [7:0] ch;
    logic [8:0] pos;
    logic       last;
  } disc_beat_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [2:0] cfg_idx_i = '0;
  logic [8:0] cfg_data_i = '0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] in_char_i = '0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] dest_o;
  logic [7:0] out_char_o;
  logic [8:0] position_o;
  logic       last_o;

  // model copy of the registers and the line state
  logic [5:0] mode_q     = ModeReset;
  logic [7:0] erase_q    = EraseReset;
  logic [7:0] kill_q     = KillReset;
  logic [7:0] eof_q      = EofReset;
  logic [7:0] eol_q      = EolReset;
  logic [7:0] intr_q     = IntrReset;
  logic [7:0] susp_q     = SuspReset;
  logic [8:0] max_line_q = MaxLineReset;
  logic [8:0] line_len_q = '0;

  logic [7:0] typed_chars[$];
  disc_beat_t disc_out_q[$];

  int tx_idle_pct = 8;
  int rx_idle_pct = 86;
  int hold_left   = 0;
  int errors      = 0;

  tty_line_discipline #(
    .MAX_LINE        (MaxLine),
    .CURSOR_LEFT_CODE(CursorLeft)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_char_i  (in_char_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .dest_o     (dest_o),
    .out_char_o (out_char_o),
    .position_o (position_o),
    .last_o     (last_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic void add_beat(dest_e d, logic [7:0] ch, logic [8:0] pos);
    disc_beat_t b;
    b.dest = d;
    b.ch   = ch;
    b.pos  = pos;
    b.last = 1'b0;
    disc_out_q.push_back(b);
  endfunction

  // expected beats of one received character, appended to disc_out_q
  function automatic void discipline_step(logic [7:0] rx);
    logic [7:0] c;
    logic [8:0] cap;
    logic [8:0] slot;
    logic       canon;
    logic       echo_on;
    logic       ends;
    int         first;
    disc_beat_t tail;
    c       = rx;
    canon   = mode_q[ModeCanon];
    echo_on = mode_q[ModeEcho];
    cap     = (max_line_q == 9'd0) ? 9'd1 :
              (max_line_q > MaxLine) ? 9'(MaxLine) : max_line_q;
    slot    = (line_len_q < cap) ? line_len_q : cap - 9'd1;
    first   = disc_out_q.size();

    if (c == ChNl && mode_q[ModeNlToCr]) c = ChCr;
    if (c == ChCr && mode_q[ModeIgnCr]) return;
    if (c == ChCr && mode_q[ModeCrToNl]) c = ChNl;

    if (canon && c == erase_q) begin
      if (line_len_q != 9'd0) line_len_q = line_len_q - 9'd1;
    end else if (canon && c == kill_q) begin
      line_len_q = 9'd0;
    end else begin
      add_beat(DEST_WRITE, c, slot);
      line_len_q = slot + 9'd1;
    end

    if (echo_on) begin
      if (canon && c == erase_q) begin
        add_beat(DEST_ECHO, CursorLeft, 9'd0);
        add_beat(DEST_ECHO, ChSpace, 9'd0);
        add_beat(DEST_ECHO, CursorLeft, 9'd0);
      end else if (canon && c == kill_q) begin
        add_beat(DEST_ECHO, ChNl, 9'd0);
      end else begin
        add_beat(DEST_ECHO, c, 9'd0);
      end
    end else if (c == ChNl && mode_q[ModeEchoNl]) begin
      add_beat(DEST_ECHO, ChNl, 9'd0);
    end

    if (canon) begin
      // an erase never terminates, even when it doubles as a line-end char
      ends = (c == eof_q || c == eol_q || c == intr_q || c == susp_q ||
              line_len_q >= cap) && c != erase_q;
      if (ends) begin
        if (line_len_q >= cap) line_len_q = cap - 9'd1;
        add_beat(DEST_WRITE, 8'd0, line_len_q);
        add_beat(DEST_LINE, 8'd0, line_len_q);
        line_len_q = 9'd0;
      end
    end else begin
      add_beat(DEST_LINE, 8'd0, line_len_q);
      line_len_q = 9'd0;
    end

    if (disc_out_q.size() > first) begin
      tail = disc_out_q.pop_back();
      tail.last = 1'b1;
      disc_out_q.push_back(tail);
    end
  endfunction

  // sender: predict on acceptance, then offer the next char or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_char_i  <= 8'd0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) discipline_step(in_char_i);
      if (typed_chars.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_valid_i <= 1'b1;
        in_char_i  <= typed_chars.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stall, with an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : result_check
    disc_beat_t want;
    disc_beat_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.dest = dest_e'(dest_o);
      got.ch   = out_char_o;
      got.pos  = position_o;
      got.last = last_o;
      if (disc_out_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: dest %0d char %h pos %0d last %0b",
                   dest_o, out_char_o, position_o, last_o);
      end else begin
        want = disc_out_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("mismatch exp/act: dest %0d/%0d char %h/%h pos %0d/%0d last %0b/%0b",
                     want.dest, dest_o, want.ch, out_char_o, want.pos, position_o,
                     want.last, last_o);
        end
      end
    end
  end

  task automatic write_reg(reg_idx_e idx, logic [8:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:     mode_q     = data[5:0];
      REG_ERASE:    erase_q    = data[7:0];
      REG_KILL:     kill_q     = data[7:0];
      REG_EOF:      eof_q      = data[7:0];
      REG_EOL:      eol_q      = data[7:0];
      REG_INTR:     intr_q     = data[7:0];
      REG_SUSP:     susp_q     = data[7:0];
      REG_MAX_LINE: max_line_q = data;
      default: ;
    endcase
  endtask

  // wait until the sender is empty and every predicted beat has come back
  task automatic settle();
    @(negedge clk_i);
    while (typed_chars.size() != 0 || in_valid_i || disc_out_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic new_setting();
    int i;
    int pick;
    logic [8:0] v;
    v = 9'($urandom_range(0, 511));
    if ($urandom_range(0, 3) != 0) v = v | FCanon;
    write_reg(REG_MODE, v);
    for (i = REG_ERASE; i <= REG_SUSP; i++) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0:       v = 9'd0;
        1:       v = 9'h0ff;
        2:       v = 9'($urandom_range(0, 511));
        default: v = 9'($urandom_range(0, 31));
      endcase
      write_reg(reg_idx_e'(i), v);
    end
    pick = $urandom_range(0, 9);
    case (pick)
      0:       v = 9'd0;
      1:       v = 9'd1;
      2:       v = 9'(MaxLine);
      3:       v = 9'h1ff;
      default: v = 9'($urandom_range(2, 12));
    endcase
    write_reg(REG_MAX_LINE, v);
  endtask

  // mostly whole lines with random text, some stray bytes and open lines
  task automatic queue_lines(int n);
    int pushed;
    int len;
    int k;
    int pick;
    logic [7:0] stop_ch;
    pushed = 0;
    while (pushed < n) begin
      if ($urandom_range(0, 99) < 15) begin
        typed_chars.push_back(8'($urandom_range(0, 255)));
        pushed++;
      end else begin
        len = $urandom_range(0, 9);
        for (k = 0; k < len; k++) begin
          pick = $urandom_range(0, 19);
          typed_chars.push_back(pick == 0 ? erase_q : pick == 1 ? kill_q :
                                8'($urandom_range(8'h20, 8'h7e)));
        end
        pushed += len;
        pick = $urandom_range(0, 6);
        case (pick)
          0:       stop_ch = eof_q;
          1:       stop_ch = eol_q;
          2:       stop_ch = intr_q;
          3:       stop_ch = susp_q;
          4:       stop_ch = ChCr;
          5:       stop_ch = ChNl;
          default: stop_ch = 8'($urandom_range(0, 255));
        endcase
        typed_chars.push_back(stop_ch);
        pushed++;
      end
    end
  endtask

  initial begin : stimulus
    int seg;
    int ph;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: erase on empty line, extremes, every terminator, cr to nl
    @(negedge clk_i);
    typed_chars = '{erase_q, 8'h41, 8'hff, 8'h00, erase_q, kill_q, 8'h62, eof_q,
                    8'h63, intr_q, 8'h64, susp_q, ChCr, 8'h65, eol_q};
    settle();

    // ignored cr, nl to cr, echo off, capacity of one via max_line 0
    write_reg(REG_MODE, FIgnCr | FNlCr | FCanon | FEchoNl);
    write_reg(REG_MAX_LINE, 9'd0);
    @(negedge clk_i);
    typed_chars = '{ChCr, ChNl, 8'h66};
    settle();

    // raw mode with echo, max_line above the build limit
    write_reg(REG_MODE, FEcho);
    write_reg(REG_MAX_LINE, 9'h1ff);
    @(negedge clk_i);
    typed_chars = '{8'h67, 8'h80};
    settle();

    // erase doubling as eof, kill doubling as eol, echo off
    write_reg(REG_MODE, FCanon | FEchoNl);
    write_reg(REG_MAX_LINE, 9'(MaxLine));
    write_reg(REG_ERASE, 9'(EofReset));
    write_reg(REG_KILL, 9'(EolReset));
    @(negedge clk_i);
    typed_chars = '{8'h68, eof_q, eol_q};
    settle();

    // shrink max_line below the stored length
    write_reg(REG_MODE, 9'(ModeReset) | FCrNl);
    write_reg(REG_ERASE, 9'(EraseReset));
    write_reg(REG_KILL, 9'(KillReset));
    @(negedge clk_i);
    typed_chars = '{8'h69, 8'h6a, 8'h6b, 8'h6c};
    settle();
    write_reg(REG_MAX_LINE, 9'd2);
    @(negedge clk_i);
    typed_chars.push_back(8'h6d);
    settle();

    for (seg = 0; seg < 3; seg++) begin
      tx_idle_pct = (seg == 0) ? 8 : (seg == 1) ? 86 : 0;
      rx_idle_pct = (seg == 0) ? 86 : (seg == 1) ? 8 : 0;
      for (ph = 0; ph < 5; ph++) begin
        new_setting();
        @(negedge clk_i);
        queue_lines(20);
        // block the output while chars keep coming, so the input backs up
        if (seg == 2 && ph == 1) hold_left = HoldCycles;
        settle();
      end
    end

    repeat (SettleCycles) @(negedge clk_i);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  initial begin : watchdog
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/tld_pkg.sv
rtl/core/tld_front.sv
rtl/core/tld_queue.sv
rtl/core/tld_back.sv
rtl/core/tty_line_discipline.sv
sim/tty_line_discipline_tb.sv
